[rtl/core/fst9_pkg.sv]
// Shared types and constants of the FAST-9 corner detector core.
package fst9_pkg;

    localparam int PIX_W  = 8;
    localparam int RING_N = 16;
    localparam int SLOTS  = 6;
    localparam int POS_W  = 10;
    localparam int STR_W  = 20;
    localparam int CNT_W  = 20;
    localparam int SQ_W   = 16;
    localparam int PART_W = 18;
    localparam int CFG_W  = 11;

    localparam logic [CNT_W-1:0] TALLY_MAX = '1;

    localparam logic [7:0]       THRESH_RST = 8'd20;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [6:0][6:0] t_win;

    localparam logic [2:0] RING_ROW [RING_N] =
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
          3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    localparam logic [2:0] RING_COL [RING_N] =
        '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
          3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             elig;
        logic             fend;
    } t_meta;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [STR_W-1:0] strength;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_result;

endpackage

[rtl/core/fst9_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module fst9_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fst9_score.sv]
// Two-stage circle test and squared-difference strength of one window.
module fst9_score
    import fst9_pkg::*;
#(
    parameter int ARC_LENGTH = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_meta            i_meta,
    input  t_win             i_win,
    input  logic [PIX_W-1:0] i_thresh,
    output logic             o_vld,
    output t_meta            o_meta,
    output logic             o_corner,
    output logic [STR_W-1:0] o_strength
);

    logic [SQ_W-1:0]   n1_sq [RING_N];
    logic [RING_N-1:0] n1_bright;
    logic [RING_N-1:0] n1_dark;
    logic [SQ_W-1:0]   r1_sq [RING_N];
    logic [RING_N-1:0] r1_bright;
    logic [RING_N-1:0] r1_dark;
    t_meta             r1_meta;
    logic              r1_vld;

    logic [PART_W-1:0] n2_part [4];
    logic              n2_corner;
    logic [PART_W-1:0] r2_part [4];
    logic              r2_corner;
    t_meta             r2_meta;
    logic              r2_vld;

    always_comb begin
        logic [PIX_W:0]   p;
        logic [PIX_W:0]   ctr;
        logic [PIX_W:0]   th;
        logic [PIX_W-1:0] ad;
        ctr = {1'b0, i_win[3][3]};
        th  = {1'b0, i_thresh};
        for (int i = 0; i < RING_N; i++) begin
            p            = {1'b0, i_win[RING_ROW[i]][RING_COL[i]]};
            n1_bright[i] = p > (ctr + th);
            n1_dark[i]   = (p + th) < ctr;
            ad           = (p > ctr) ? PIX_W'(p - ctr) : PIX_W'(ctr - p);
            n1_sq[i]     = SQ_W'(ad) * SQ_W'(ad);
        end
    end

    always_comb begin
        logic hit_b;
        logic hit_d;
        n2_corner = 1'b0;
        for (int i = 0; i < RING_N; i++) begin
            hit_b = 1'b1;
            hit_d = 1'b1;
            for (int j = 0; j < ARC_LENGTH; j++) begin
                hit_b = hit_b & r1_bright[(i + j) % RING_N];
                hit_d = hit_d & r1_dark[(i + j) % RING_N];
            end
            n2_corner = n2_corner | hit_b | hit_d;
        end
        for (int g = 0; g < 4; g++) begin
            n2_part[g] = PART_W'(r1_sq[4*g]) + PART_W'(r1_sq[4*g+1])
                       + PART_W'(r1_sq[4*g+2]) + PART_W'(r1_sq[4*g+3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sq     <= n1_sq;
            r1_bright <= n1_bright;
            r1_dark   <= n1_dark;
            r1_meta   <= i_meta;
            r2_part   <= n2_part;
            r2_corner <= n2_corner;
            r2_meta   <= r1_meta;
        end
    end

    assign o_vld      = r2_vld;
    assign o_meta     = r2_meta;
    assign o_corner   = r2_corner;
    assign o_strength = STR_W'(r2_part[0]) + STR_W'(r2_part[1])
                      + STR_W'(r2_part[2]) + STR_W'(r2_part[3]);

endmodule

[rtl/core/fst9_outq.sv]
// Four-entry result queue taking up to two results per cycle.
module fst9_outq
    import fst9_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result i_res0,
    input  t_result i_res1,
    output logic    o_room,
    output logic    o_vld,
    input  logic    i_ready,
    output t_result o_res
);

    t_result    r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign pop    = o_vld & i_ready;
    assign o_vld  = r_cnt != 3'd0;
    assign o_room = r_cnt <= 3'd2;
    assign o_res  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push_n;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push_n} - {2'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_res1;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("result queue overfilled");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n == 2'd2 |-> r_cnt <= 3'd2) else $error("double push without room");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> !pop) else $error("pop from empty queue");

endmodule

[rtl/core/fast9_corner_detector_core.sv]
// Top level of the FAST-9 corner detector: line store, window, position and results.
//
// channel   dir  width            content
// s_axis    in   tdata 8          pixel, raster order
// m_axis    out  tdata 64, user 1 corner result or end-of-frame summary
// cfg       in   index 2, data 11 threshold, width, height
//
// One pixel per clock while the result queue has room, else the pipeline stalls.
// Line store: one RAM word per column holds six rows; read at accept, written back
// on the next advance, with forwarding when the same column is hit back to back.
// Reset clears positions, tally, pipeline and queue; stores need no clearing.
// Stall: the whole pipeline holds while the four-entry result queue has fewer
// than two free entries.
module fast9_corner_detector_core
    import fst9_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ARC_LENGTH = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] pixel
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // x, y, strength, corner_count
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int CMPW = 14;
    localparam int LW   = SLOTS * PIX_W;

    logic [PIX_W-1:0] r_thresh;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    logic [CMPW-1:0] w_eff;
    logic [CMPW-1:0] h_eff;
    logic [CMPW-1:0] c_ext;
    logic [CMPW-1:0] r_ext;
    logic            col_wrap;
    logic            row_wrap;

    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [2:0]    r_slot;

    logic adv;
    logic accept;

    logic             r_b_vld;
    logic [PIX_W-1:0] r_b_pix;
    logic [2:0]       r_b_slot;
    logic [XW-1:0]    r_b_addr;
    t_meta            r_b_meta;
    t_meta            n_b_meta;
    logic             r_fwd;
    logic [LW-1:0]    r_fwd_data;

    logic [LW-1:0]    ram_rdata;
    logic [LW-1:0]    b_word;
    logic [LW-1:0]    b_wword;
    logic             b_we;
    t_pix             b_col [7];

    t_win  r_win;
    logic  r_c_vld;
    t_meta r_c_meta;

    logic             s_vld;
    t_meta            s_meta;
    logic             s_corner;
    logic [STR_W-1:0] s_strength;

    logic             corner_hit;
    logic             is_sum;
    logic [CNT_W-1:0] r_tally;
    logic [CNT_W-1:0] tally_inc;
    t_result          res_corner;
    t_result          res_sum;
    t_result          res0;
    t_result          q_res;
    logic [1:0]       push_n;
    logic             room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_THRESH: r_thresh <= i_cfg_wdata[PIX_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_wdata;
                REG_HEIGHT: r_height <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = CMPW'(1);
        end else if (CMPW'(r_height) > CMPW'(MAX_HEIGHT)) begin
            h_eff = CMPW'(MAX_HEIGHT);
        end else begin
            h_eff = CMPW'(r_height);
        end
        c_ext    = CMPW'(r_col);
        r_ext    = CMPW'(r_row);
        col_wrap = (c_ext + CMPW'(1)) >= w_eff;
        row_wrap = (r_ext + CMPW'(1)) >= h_eff;
        n_b_meta.x    = POS_W'(c_ext - CMPW'(3));
        n_b_meta.y    = POS_W'(r_ext - CMPW'(3));
        n_b_meta.elig = (c_ext >= CMPW'(6)) && (r_ext >= CMPW'(6))
                      && (c_ext < w_eff) && (r_ext < h_eff);
        n_b_meta.fend = col_wrap && row_wrap;
    end

    assign adv           = room;
    assign accept        = s_axis_tvalid & adv;
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col <= '0;
                if (row_wrap) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + YW'(1);
                    r_slot <= (r_slot == 3'(SLOTS - 1)) ? 3'd0 : r_slot + 3'd1;
                end
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    fst9_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (r_b_addr),
        .i_wdata (b_wword),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign b_we   = adv & r_b_vld;
    assign b_word = r_fwd ? r_fwd_data : ram_rdata;

    always_comb begin
        logic [3:0] idx;
        for (int k = 0; k < SLOTS; k++) begin
            idx = 4'(r_b_slot) + 4'(k);
            if (idx >= 4'(SLOTS)) begin
                idx = idx - 4'(SLOTS);
            end
            b_col[k] = b_word[idx*PIX_W +: PIX_W];
        end
        b_col[SLOTS] = r_b_pix;
        for (int s = 0; s < SLOTS; s++) begin
            b_wword[s*PIX_W +: PIX_W] = (3'(s) == r_b_slot) ? r_b_pix
                                                           : b_word[s*PIX_W +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= accept;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix    <= s_axis_tdata;
            r_b_slot   <= r_slot;
            r_b_addr   <= r_col;
            r_b_meta   <= n_b_meta;
            r_fwd      <= b_we && (r_b_addr == r_col);
            r_fwd_data <= b_wword;
        end
        if (b_we) begin
            for (int k = 0; k < 7; k++) begin
                for (int j = 0; j < 6; j++) begin
                    r_win[k][j] <= r_win[k][j+1];
                end
                r_win[k][6] <= b_col[k];
            end
            r_c_meta <= r_b_meta;
        end
    end

    fst9_score #(
        .ARC_LENGTH (ARC_LENGTH)
    ) u_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_vld      (r_c_vld),
        .i_meta     (r_c_meta),
        .i_win      (r_win),
        .i_thresh   (r_thresh),
        .o_vld      (s_vld),
        .o_meta     (s_meta),
        .o_corner   (s_corner),
        .o_strength (s_strength)
    );

    assign corner_hit = adv & s_vld & s_meta.elig & s_corner;
    assign is_sum     = adv & s_vld & s_meta.fend;
    assign tally_inc  = (corner_hit && r_tally != TALLY_MAX) ? r_tally + CNT_W'(1) : r_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (is_sum) begin
            r_tally <= '0;
        end else begin
            r_tally <= tally_inc;
        end
    end

    always_comb begin
        res_corner.kind     = 1'b0;
        res_corner.x        = s_meta.x;
        res_corner.y        = s_meta.y;
        res_corner.strength = s_strength;
        res_corner.count    = '0;
        res_corner.last     = !s_meta.fend;
        res_sum.kind        = 1'b1;
        res_sum.x           = '0;
        res_sum.y           = '0;
        res_sum.strength    = '0;
        res_sum.count       = tally_inc;
        res_sum.last        = 1'b1;
        res0   = corner_hit ? res_corner : res_sum;
        push_n = {1'b0, corner_hit} + {1'b0, is_sum};
    end

    fst9_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res_sum),
        .o_room   (room),
        .o_vld    (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (q_res)
    );

    assign m_axis_tdata = {4'b0, q_res.count, q_res.strength, q_res.y, q_res.x};
    assign m_axis_tuser = q_res.kind;
    assign m_axis_tlast = q_res.last;

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_vld) else $error("accepted pixel lost before line store");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < 3'(SLOTS)) else $error("line slot out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_c_vld) && $stable(r_b_vld)) else $error("pipeline moved in stall");
    a_fwd_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && b_we && (r_b_addr == r_col) |=> r_fwd) else $error("missed forward");

endmodule
